// File: hw/rtl/ansi_cell_to_escape_encoder_defines.svh
`ifndef ANSI_CELL_TO_ESCAPE_ENCODER_DEFINES_SVH
`define ANSI_CELL_TO_ESCAPE_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ACTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ACTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/acte_pkg.sv
package acte_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIM_W      = 12;
  localparam int COLOR_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int UPC_W      = 6;
  localparam int CMP_W      = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;

  localparam logic [DIM_W-1:0]   RST_COLUMNS    = DIM_W'(80);
  localparam logic [DIM_W-1:0]   RST_ROWS       = DIM_W'(24);
  localparam logic [COLOR_W-1:0] RST_DEFAULT_FG = COLOR_W'(7);
  localparam logic [COLOR_W-1:0] RST_DEFAULT_BG = COLOR_W'(0);

  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
  localparam logic [BYTE_W-1:0] CH_M     = 8'h6d;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

  localparam logic [55:0] SEQ_BG  = 56'h3b353b38345b1b;
  localparam logic [55:0] SEQ_FG  = 56'h3b353b38335b1b;
  localparam logic [31:0] SEQ_END = 32'h6d305b1b;

  localparam logic [UPC_W-1:0] UPC_WAIT  = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_START = UPC_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS    = 2'd0,
    REG_ROWS       = 2'd1,
    REG_DEFAULT_FG = 2'd2,
    REG_DEFAULT_BG = 2'd3
  } cfg_idx_e_t;

  typedef enum logic [1:0] {
    EC_ALWAYS = 2'd0,
    EC_GE100  = 2'd1,
    EC_GE10   = 2'd2
  } econd_t;

  typedef enum logic [2:0] {
    SRC_LIT   = 3'd0,
    SRC_GLYPH = 3'd1,
    SRC_DIGH  = 3'd2,
    SRC_DIGT  = 3'd3,
    SRC_DIGO  = 3'd4
  } src_t;

  typedef enum logic {
    CS_BG = 1'b0,
    CS_FG = 1'b1
  } csel_t;

  typedef enum logic [1:0] {
    FIN_NONE  = 2'd0,
    FIN_JUMP  = 2'd1,
    FIN_FRAME = 2'd2
  } fin_t;

  typedef enum logic [2:0] {
    JC_NEXT        = 3'd0,
    JC_ALWAYS      = 3'd1,
    JC_NO_START    = 3'd2,
    JC_NO_BG       = 3'd3,
    JC_NO_FG       = 3'd4,
    JC_NO_ROWEND   = 3'd5,
    JC_NO_FRAMEEND = 3'd6
  } jcond_t;

  typedef struct packed {
    logic              emit;
    econd_t            econd;
    src_t              src;
    logic [BYTE_W-1:0] lit;
    csel_t             csel;
    fin_t              fin;
    jcond_t            jcond;
    logic [UPC_W-1:0]  target;
  } ucw_t;

  typedef struct packed {
    logic              push;
    src_t              src;
    logic [BYTE_W-1:0] lit;
    csel_t             csel;
    logic              last;
    logic              frame_end;
  } ctl_t;

  typedef struct packed {
    logic slot_free;
    logic start;
    logic bg_diff;
    logic fg_diff;
    logic row_end;
    logic frame_end;
    logic ge100;
    logic ge10;
  } stat_t;

  typedef struct packed {
    logic [DIM_W-1:0]   columns;
    logic [DIM_W-1:0]   rows;
    logic [COLOR_W-1:0] default_fg;
    logic [COLOR_W-1:0] default_bg;
  } cfg_t;

  typedef struct packed {
    logic [1:0] h;
    logic [3:0] t;
    logic [3:0] o;
    logic       ge100;
    logic       ge10;
  } digits_t;

  // decimal digits of color + 1
  function automatic digits_t color_digits(logic [COLOR_W-1:0] c);
    digits_t    d;
    logic [8:0] v;
    logic [6:0] r;
    logic [14:0] p;
    v = {1'b0, c} + 9'd1;
    if (v >= 9'd200) begin
      d.h = 2'd2;
      r   = 7'(v - 9'd200);
    end else if (v >= 9'd100) begin
      d.h = 2'd1;
      r   = 7'(v - 9'd100);
    end else begin
      d.h = 2'd0;
      r   = v[6:0];
    end
    p       = 15'(r) * 15'd205;
    d.t     = p[14:11];
    d.o     = 4'(r - 7'(d.t) * 7'd10);
    d.ge100 = (v >= 9'd100);
    d.ge10  = (v >= 9'd10);
    return d;
  endfunction

  function automatic ucw_t uc_lit(logic [BYTE_W-1:0] b);
    ucw_t w;
    w = '{emit: 1'b1, econd: EC_ALWAYS, src: SRC_LIT, lit: b, csel: CS_BG,
          fin: FIN_NONE, jcond: JC_NEXT, target: '0};
    return w;
  endfunction

  function automatic ucw_t uc_dig(src_t s, econd_t e, csel_t cs);
    ucw_t w;
    w = '{emit: 1'b1, econd: e, src: s, lit: '0, csel: cs,
          fin: FIN_NONE, jcond: JC_NEXT, target: '0};
    return w;
  endfunction

  function automatic ucw_t uc_jmp(jcond_t j, logic [UPC_W-1:0] tgt);
    ucw_t w;
    w = '{emit: 1'b0, econd: EC_ALWAYS, src: SRC_LIT, lit: '0, csel: CS_BG,
          fin: FIN_NONE, jcond: j, target: tgt};
    return w;
  endfunction

  // control store
  function automatic ucw_t ucode(logic [UPC_W-1:0] a);
    ucw_t w;
    case (a)
      6'd0:  w = uc_jmp(JC_NEXT, UPC_WAIT);
      6'd1:  w = uc_jmp(JC_NO_START, 6'd5);
      6'd2:  w = uc_lit(CH_ESC);
      6'd3:  w = uc_lit(CH_LBR);
      6'd4:  w = uc_lit(CH_H);
      6'd5:  w = uc_jmp(JC_NO_BG, 6'd17);
      6'd6:  w = uc_lit(SEQ_BG[7:0]);
      6'd7:  w = uc_lit(SEQ_BG[15:8]);
      6'd8:  w = uc_lit(SEQ_BG[23:16]);
      6'd9:  w = uc_lit(SEQ_BG[31:24]);
      6'd10: w = uc_lit(SEQ_BG[39:32]);
      6'd11: w = uc_lit(SEQ_BG[47:40]);
      6'd12: w = uc_lit(SEQ_BG[55:48]);
      6'd13: w = uc_dig(SRC_DIGH, EC_GE100, CS_BG);
      6'd14: w = uc_dig(SRC_DIGT, EC_GE10, CS_BG);
      6'd15: w = uc_dig(SRC_DIGO, EC_ALWAYS, CS_BG);
      6'd16: w = uc_lit(CH_M);
      6'd17: w = uc_jmp(JC_NO_FG, 6'd29);
      6'd18: w = uc_lit(SEQ_FG[7:0]);
      6'd19: w = uc_lit(SEQ_FG[15:8]);
      6'd20: w = uc_lit(SEQ_FG[23:16]);
      6'd21: w = uc_lit(SEQ_FG[31:24]);
      6'd22: w = uc_lit(SEQ_FG[39:32]);
      6'd23: w = uc_lit(SEQ_FG[47:40]);
      6'd24: w = uc_lit(SEQ_FG[55:48]);
      6'd25: w = uc_dig(SRC_DIGH, EC_GE100, CS_FG);
      6'd26: w = uc_dig(SRC_DIGT, EC_GE10, CS_FG);
      6'd27: w = uc_dig(SRC_DIGO, EC_ALWAYS, CS_FG);
      6'd28: w = uc_lit(CH_M);
      6'd29: begin
        w        = uc_dig(SRC_GLYPH, EC_ALWAYS, CS_BG);
        w.fin    = FIN_JUMP;
        w.jcond  = JC_NO_ROWEND;
        w.target = UPC_WAIT;
      end
      6'd30: begin
        w        = uc_lit(CH_NL);
        w.fin    = FIN_JUMP;
        w.jcond  = JC_NO_FRAMEEND;
        w.target = UPC_WAIT;
      end
      6'd31: w = uc_lit(SEQ_END[7:0]);
      6'd32: w = uc_lit(SEQ_END[15:8]);
      6'd33: w = uc_lit(SEQ_END[23:16]);
      6'd34: begin
        w        = uc_lit(SEQ_END[31:24]);
        w.fin    = FIN_FRAME;
        w.jcond  = JC_ALWAYS;
        w.target = UPC_WAIT;
      end
      default: w = uc_jmp(JC_ALWAYS, UPC_WAIT);
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/acte_ifs.sv
interface acte_in_if import acte_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] glyph;
  logic [COLOR_W-1:0] fore_color;
  logic [COLOR_W-1:0] back_color;

  modport source (output valid, glyph, fore_color, back_color, input ready);
  modport sink   (input valid, glyph, fore_color, back_color, output ready);
endinterface

interface acte_out_if import acte_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  logic              frame_end;

  modport source (output valid, out_byte, last, frame_end, input ready);
  modport sink   (input valid, out_byte, last, frame_end, output ready);
endinterface

interface acte_cfg_if import acte_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/acte_sequencer.sv
module acte_sequencer import acte_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  stat_t stat,
  output ctl_t  ctl,
  output logic  idle
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  ucw_t             cw;
  logic             econd_ok;
  logic             want;
  logic             go;
  logic             taken;

  assign cw = ucode(upc_r);

  always_comb begin
    case (cw.econd)
      EC_ALWAYS: econd_ok = 1'b1;
      EC_GE100:  econd_ok = stat.ge100;
      EC_GE10:   econd_ok = stat.ge10;
      default:   econd_ok = 1'b1;
    endcase
  end

  always_comb begin
    case (cw.jcond)
      JC_NEXT:        taken = 1'b0;
      JC_ALWAYS:      taken = 1'b1;
      JC_NO_START:    taken = !stat.start;
      JC_NO_BG:       taken = !stat.bg_diff;
      JC_NO_FG:       taken = !stat.fg_diff;
      JC_NO_ROWEND:   taken = !stat.row_end;
      JC_NO_FRAMEEND: taken = !stat.frame_end;
      default:        taken = 1'b0;
    endcase
  end

  assign want = cw.emit && econd_ok;
  assign go   = !want || stat.slot_free;
  assign idle = (upc_r == UPC_WAIT);

  always_comb begin
    if (idle) begin
      upc_nxt = in_fire ? UPC_START : UPC_WAIT;
    end else if (go) begin
      upc_nxt = taken ? cw.target : upc_r + UPC_W'(1);
    end else begin
      upc_nxt = upc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctl.push      = want && stat.slot_free && !idle;
  assign ctl.src       = cw.src;
  assign ctl.lit       = cw.lit;
  assign ctl.csel      = cw.csel;
  assign ctl.last      = ((cw.fin == FIN_JUMP) && taken) || (cw.fin == FIN_FRAME);
  assign ctl.frame_end = (cw.fin == FIN_FRAME);

endmodule

// File: hw/rtl/acte_datapath.sv
module acte_datapath import acte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_fire,
  input  logic [COLOR_W-1:0] in_glyph,
  input  logic [COLOR_W-1:0] in_fore,
  input  logic [COLOR_W-1:0] in_back,
  input  ctl_t               ctl,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last,
  output logic               out_frame_end,
  output stat_t              stat
);

  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COLOR_W-1:0]    prev_fore_r, prev_back_r;
  logic [COLOR_W-1:0]    glyph_r, fore_r, back_r;
  logic                  start_r, bg_diff_r, fg_diff_r, row_end_r, frame_end_r;
  logic                  out_valid_r;
  logic [BYTE_W-1:0]     out_byte_r;
  logic                  out_last_r, out_frame_end_r;

  logic                  start;
  logic [COLOR_W-1:0]    eff_fore, eff_back;
  logic [COORD_BITS:0]   col_inc, row_inc;
  logic                  row_end, frame_end;
  logic                  slot_free;
  digits_t               dig;
  logic [BYTE_W-1:0]     byte_sel;

  // cell bookkeeping at accept
  assign start    = (col_r == '0) && (row_r == '0);
  assign eff_fore = start ? cfg.default_fg : prev_fore_r;
  assign eff_back = start ? cfg.default_bg : prev_back_r;
  assign col_inc  = {1'b0, col_r} + (COORD_BITS+1)'(1);
  assign row_inc  = {1'b0, row_r} + (COORD_BITS+1)'(1);
  assign row_end  = col_inc[COORD_BITS] || (CMP_W'(col_inc) >= CMP_W'(cfg.columns));
  assign frame_end = row_inc[COORD_BITS] || (CMP_W'(row_inc) >= CMP_W'(cfg.rows));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_inc[COORD_BITS-1:0];
      end else begin
        col_nxt = col_inc[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      prev_fore_r <= RST_DEFAULT_FG;
      prev_back_r <= RST_DEFAULT_BG;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_fire) begin
        prev_fore_r <= in_fore;
        prev_back_r <= in_back;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      glyph_r     <= in_glyph;
      fore_r      <= in_fore;
      back_r      <= in_back;
      start_r     <= start;
      bg_diff_r   <= (in_back != eff_back);
      fg_diff_r   <= (in_fore != eff_fore);
      row_end_r   <= row_end;
      frame_end_r <= row_end && frame_end;
    end
  end

  // byte source selection
  assign dig = color_digits((ctl.csel == CS_FG) ? fore_r : back_r);

  always_comb begin
    case (ctl.src)
      SRC_LIT:   byte_sel = ctl.lit;
      SRC_GLYPH: byte_sel = (glyph_r == '0) ? CH_SPACE : glyph_r;
      SRC_DIGH:  byte_sel = CH_ZERO + BYTE_W'(dig.h);
      SRC_DIGT:  byte_sel = CH_ZERO + BYTE_W'(dig.t);
      SRC_DIGO:  byte_sel = CH_ZERO + BYTE_W'(dig.o);
      default:   byte_sel = ctl.lit;
    endcase
  end

  // output register
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      out_byte_r      <= byte_sel;
      out_last_r      <= ctl.last;
      out_frame_end_r <= ctl.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_frame_end = out_frame_end_r;

  assign stat.slot_free = slot_free;
  assign stat.start     = start_r;
  assign stat.bg_diff   = bg_diff_r;
  assign stat.fg_diff   = fg_diff_r;
  assign stat.row_end   = row_end_r;
  assign stat.frame_end = frame_end_r;
  assign stat.ge100     = dig.ge100;
  assign stat.ge10      = dig.ge10;

endmodule

// File: hw/rtl/ansi_cell_to_escape_encoder.sv
// ansi_cell_to_escape_encoder: character cells in, terminal byte stream out.
// in_cell: one transaction per cell (glyph, fore_color, back_color), raster order.
// out_cell: one transaction per output byte; last marks the final byte of a
//   cell, frame_end the closing 'm' of the frame.
// cfg_wr: register writes (0 columns, 1 rows, 2 default_fg, 3 default_bg),
//   always ready, to be written only while the encoder is idle.
// a microcoded sequencer steps one control word per cycle, except while it waits idle or an
//   emitting step waits for output room; each emitting step whose condition holds pushes one byte.
// a cell is accepted only while the sequencer waits at its idle step, so one
//   cell is in flight at a time.
// per cell the sequencer steps through a plain glyph path; the frame header, each color
//   sequence (digit steps are stepped through even when skipped), the newline and
//   the frame trailer add steps; receiver stalls hold it further.
// the first byte of a cell is put into the output register after the frame-start test step.
// reset (rst_n low, synchronous) restores the register defaults (80, 24, 7, 0),
//   clears the row and column counters and empties the output register.
// when out_cell.ready is low while the output register is full, the sequencer holds on its
//   current emitting step; nothing is dropped or repeated.
`include "ansi_cell_to_escape_encoder_defines.svh"

module ansi_cell_to_escape_encoder import acte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  acte_in_if.sink    in_cell,
  acte_out_if.source out_cell,
  acte_cfg_if.sink   cfg_wr
);

  cfg_t  cfg_r;
  logic  in_fire;
  logic  idle;
  ctl_t  ctl;
  stat_t stat;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns    <= RST_COLUMNS;
      cfg_r.rows       <= RST_ROWS;
      cfg_r.default_fg <= RST_DEFAULT_FG;
      cfg_r.default_bg <= RST_DEFAULT_BG;
    end else if (cfg_wr.valid) begin
      case (cfg_idx_e_t'(cfg_wr.index))
        REG_COLUMNS:    cfg_r.columns    <= DIM_W'(cfg_wr.data);
        REG_ROWS:       cfg_r.rows       <= DIM_W'(cfg_wr.data);
        REG_DEFAULT_FG: cfg_r.default_fg <= cfg_wr.data[COLOR_W-1:0];
        REG_DEFAULT_BG: cfg_r.default_bg <= cfg_wr.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_cell.ready = idle;
  assign in_fire       = in_cell.valid && idle;

  acte_sequencer u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .stat    (stat),
    .ctl     (ctl),
    .idle    (idle)
  );

  acte_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_fire       (in_fire),
    .in_glyph      (in_cell.glyph),
    .in_fore       (in_cell.fore_color),
    .in_back       (in_cell.back_color),
    .ctl           (ctl),
    .out_ready     (out_cell.ready),
    .out_valid     (out_cell.valid),
    .out_byte      (out_cell.out_byte),
    .out_last      (out_cell.last),
    .out_frame_end (out_cell.frame_end),
    .stat          (stat)
  );

  `ACTE_ASSERT_NXT(a_busy_after_accept, in_fire, !in_cell.ready, "ready after accept")
  `ACTE_ASSERT_IMP(a_no_push_when_idle, in_cell.ready, !ctl.push, "byte pushed while idle")
  `ACTE_ASSERT_IMP(a_empty_after_reset, $past(!rst_n), !out_cell.valid, "output after reset")

endmodule

// File: sim/acte_byte_stream_checker.sv
`timescale 1ns / 1ps

module acte_byte_stream_checker import acte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  acte_in_if          cell_mon,
  acte_out_if         byte_mon,
  acte_cfg_if         cfg_mon,
  output int unsigned mismatch_count,
  output int unsigned bytes_pending,
  output int unsigned bytes_checked,
  output int unsigned frames_closed
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              frame_end;
  } term_byte_t;

  term_byte_t expected_bytes[$];
  term_byte_t want;
  term_byte_t got;

  logic [DIM_W-1:0]      columns_r;
  logic [DIM_W-1:0]      rows_r;
  logic [COLOR_W-1:0]    dflt_fg;
  logic [COLOR_W-1:0]    dflt_bg;
  logic [COLOR_W-1:0]    prev_fg;
  logic [COLOR_W-1:0]    prev_bg;
  logic [COORD_BITS-1:0] col_pos;
  logic [COORD_BITS-1:0] row_pos;

  function automatic void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void queue_byte(logic [BYTE_W-1:0] b);
    term_byte_t e;
    e.data      = b;
    e.last      = 1'b0;
    e.frame_end = 1'b0;
    expected_bytes.push_back(e);
  endfunction

  // lead-in, decimal of color + 1 without leading zeros, closing m
  function automatic void queue_color(logic [55:0] lead, logic [COLOR_W-1:0] color);
    int v;
    int i;
    v = int'(color) + 1;
    for (i = 0; i < 7; i++) begin
      queue_byte(lead[8*i +: 8]);
    end
    if (v >= 100) begin
      queue_byte(CH_ZERO + 8'(v / 100));
    end
    if (v >= 10) begin
      queue_byte(CH_ZERO + 8'((v / 10) % 10));
    end
    queue_byte(CH_ZERO + 8'(v % 10));
    queue_byte(CH_M);
  endfunction

  function automatic void encode_cell(logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] f,
                                      logic [COLOR_W-1:0] b);
    logic [COORD_BITS:0] nxt;
    logic                closes_frame;
    term_byte_t          tail;
    int                  i;
    closes_frame = 1'b0;
    if (col_pos == '0 && row_pos == '0) begin
      queue_byte(CH_ESC);
      queue_byte(CH_LBR);
      queue_byte(CH_H);
      prev_fg = dflt_fg;
      prev_bg = dflt_bg;
    end
    if (b != prev_bg) begin
      queue_color(SEQ_BG, b);
    end
    if (f != prev_fg) begin
      queue_color(SEQ_FG, f);
    end
    prev_fg = f;
    prev_bg = b;
    queue_byte((g == '0) ? CH_SPACE : g);

    // row or frame ends at the limit, or when the counter would overflow
    nxt = {1'b0, col_pos} + 1'b1;
    if (nxt >= columns_r || nxt[COORD_BITS]) begin
      queue_byte(CH_NL);
      col_pos = '0;
      nxt = {1'b0, row_pos} + 1'b1;
      if (nxt >= rows_r || nxt[COORD_BITS]) begin
        for (i = 0; i < 4; i++) begin
          queue_byte(SEQ_END[8*i +: 8]);
        end
        row_pos      = '0;
        closes_frame = 1'b1;
      end else begin
        row_pos = nxt[COORD_BITS-1:0];
      end
    end else begin
      col_pos = nxt[COORD_BITS-1:0];
    end

    tail           = expected_bytes.pop_back();
    tail.last      = 1'b1;
    tail.frame_end = closes_frame;
    expected_bytes.push_back(tail);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_bytes.delete();
      columns_r      = RST_COLUMNS;
      rows_r         = RST_ROWS;
      dflt_fg        = RST_DEFAULT_FG;
      dflt_bg        = RST_DEFAULT_BG;
      prev_fg        = RST_DEFAULT_FG;
      prev_bg        = RST_DEFAULT_BG;
      col_pos        = '0;
      row_pos        = '0;
      mismatch_count = 0;
      bytes_checked  = 0;
      frames_closed  = 0;
    end else begin
      // byte transaction first: it can never belong to a cell taken this cycle
      if (byte_mon.valid && byte_mon.ready) begin
        got.data      = byte_mon.out_byte;
        got.last      = byte_mon.last;
        got.frame_end = byte_mon.frame_end;
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("unexpected byte %h last %b frame_end %b",
                               got.data, got.last, got.frame_end));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (want.frame_end) begin
            frames_closed++;
          end
          if (got != want) begin
            flag_error($sformatf(
              "byte %0d: expected %h last %b frame_end %b, got %h last %b frame_end %b",
              bytes_checked, want.data, want.last, want.frame_end,
              got.data, got.last, got.frame_end));
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_COLUMNS:    columns_r = cfg_mon.data[DIM_W-1:0];
          REG_ROWS:       rows_r    = cfg_mon.data[DIM_W-1:0];
          REG_DEFAULT_FG: dflt_fg   = cfg_mon.data[COLOR_W-1:0];
          REG_DEFAULT_BG: dflt_bg   = cfg_mon.data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (cell_mon.valid && cell_mon.ready) begin
        encode_cell(cell_mon.glyph, cell_mon.fore_color, cell_mon.back_color);
      end
    end
    bytes_pending <= expected_bytes.size();
  end

endmodule

// File: sim/ansi_cell_to_escape_encoder_tb.sv
`timescale 1ns / 1ps

module ansi_cell_to_escape_encoder_tb;
  import acte_pkg::*;

  localparam int N_CELLS = 460;

  logic clk;
  logic rst_n;
  bit   calm;

  int unsigned mismatches;
  int unsigned bytes_pending;
  int unsigned bytes_checked;
  int unsigned frames_closed;
  int unsigned cells_sent;
  int unsigned settings_used;

  logic [COLOR_W-1:0] last_fg;
  logic [COLOR_W-1:0] last_bg;
  logic [COLOR_W-1:0] cur_dfg;
  logic [COLOR_W-1:0] cur_dbg;

  acte_in_if  cell_ch ();
  acte_out_if byte_ch ();
  acte_cfg_if cfg_ch ();

  ansi_cell_to_escape_encoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cell  (cell_ch),
    .out_cell (byte_ch),
    .cfg_wr   (cfg_ch)
  );

  acte_byte_stream_checker u_stream_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cell_mon       (cell_ch),
    .byte_mon       (byte_ch),
    .cfg_mon        (cfg_ch),
    .mismatch_count (mismatches),
    .bytes_pending  (bytes_pending),
    .bytes_checked  (bytes_checked),
    .frames_closed  (frames_closed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d cells sent, %0d bytes still expected", cells_sent, bytes_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [DIM_W-1:0] pick_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return DIM_W'($urandom_range(1, 4));
    end else if (r < 80) begin
      return DIM_W'($urandom_range(5, 16));
    end else if (r < 88) begin
      return '0;
    end else if (r < 94) begin
      return '1;
    end
    return DIM_W'($urandom_range(0, 4095));
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color(logic [COLOR_W-1:0] prev,
                                                    logic [COLOR_W-1:0] dflt);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return prev;
    end else if (r == 5) begin
      return dflt;
    end else if (r == 6) begin
      return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    end
    return COLOR_W'($urandom_range(0, 255));
  endfunction

  // sink side stall pattern
  initial begin
    int run;
    int gap;
    byte_ch.ready <= 1'b0;
    forever begin
      run = $urandom_range(1, 12);
      byte_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap != 0) begin
        byte_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send_cell(input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] f,
                           input logic [COLOR_W-1:0] b);
    int gap;
    gap = idle_len();
    if (gap != 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_ch.valid      <= 1'b1;
    cell_ch.glyph      <= g;
    cell_ch.fore_color <= f;
    cell_ch.back_color <= b;
    do @(posedge clk); while (!cell_ch.ready);
    last_fg = f;
    last_bg = b;
    cells_sent++;
  endtask

  task automatic settle();
    cell_ch.valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
  endtask

  // registers are written only once every expected byte is out
  task automatic program_regs(input logic [3:0] mask, input logic [DIM_W-1:0] cols,
                              input logic [DIM_W-1:0] rws, input logic [COLOR_W-1:0] dfg,
                              input logic [COLOR_W-1:0] dbg);
    int idx;
    settle();
    for (idx = 0; idx < 4; idx++) begin
      if (mask[idx]) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= cfg_idx_e_t'(idx);
        case (cfg_idx_e_t'(idx))
          REG_COLUMNS:    cfg_ch.data <= cols;
          REG_ROWS:       cfg_ch.data <= rws;
          REG_DEFAULT_FG: begin
            cfg_ch.data <= {4'($urandom), dfg};
            cur_dfg = dfg;
          end
          default: begin
            cfg_ch.data <= {4'($urandom), dbg};
            cur_dbg = dbg;
          end
        endcase
        do @(posedge clk); while (!cfg_ch.ready);
      end
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int burst;
    logic [3:0] mask;
    cell_ch.valid      <= 1'b0;
    cell_ch.glyph      <= '0;
    cell_ch.fore_color <= '0;
    cell_ch.back_color <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_COLUMNS;
    cfg_ch.data        <= '0;
    rst_n              <= 1'b0;
    calm       = 1'b0;
    cells_sent = 0;
    settings_used = 1;
    cur_dfg    = RST_DEFAULT_FG;
    cur_dbg    = RST_DEFAULT_BG;
    last_fg    = RST_DEFAULT_FG;
    last_bg    = RST_DEFAULT_BG;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry and colors, blank glyph, one to three digit colors
    send_cell(8'h00, 8'd7, 8'd0);
    send_cell(8'hff, 8'hff, 8'hff);
    send_cell(8'h41, 8'd8, 8'd98);
    send_cell(8'h7f, 8'd9, 8'd99);
    send_cell(8'h01, 8'd9, 8'd99);

    // zero geometry: every cell closes a row and a frame
    program_regs(4'b1111, '0, '0, 8'h00, 8'hff);
    send_cell(8'h00, 8'h00, 8'hff);
    send_cell(8'h55, 8'd200, 8'd7);

    // row counter already past a lowered row limit
    program_regs(4'b0011, 12'd1, '1, 8'h00, 8'h00);
    send_cell(8'h80, 8'h00, 8'hff);
    send_cell(8'h2a, 8'h01, 8'hfe);
    send_cell(8'h00, 8'h01, 8'hfe);
    program_regs(4'b0010, '0, 12'd1, 8'h00, 8'h00);
    send_cell(8'h7e, 8'h01, 8'hfe);

    // column counter already past a lowered column limit
    program_regs(4'b0011, '1, 12'd2, 8'h00, 8'h00);
    repeat (5) send_cell(8'h33, 8'h10, 8'h20);
    program_regs(4'b0001, 12'd2, '0, 8'h00, 8'h00);
    send_cell(8'h34, 8'h10, 8'h20);
    send_cell(8'h35, 8'h11, 8'h20);

    // defaults changed mid-frame apply from the next frame start
    program_regs(4'b1111, 12'd3, 12'd2, 8'd4, 8'd5);
    repeat (5) send_cell(8'h36, 8'd4, 8'd5);

    while (cells_sent < N_CELLS) begin
      mask = 4'($urandom_range(0, 15));
      calm = ($urandom_range(0, 4) == 0);
      program_regs(mask, pick_extent(), pick_extent(),
                   ($urandom_range(0, 3) == 0) ? 8'hff : COLOR_W'($urandom_range(0, 255)),
                   ($urandom_range(0, 3) == 0) ? 8'h00 : COLOR_W'($urandom_range(0, 255)));
      burst = $urandom_range(5, 40);
      while (burst > 0 && cells_sent < N_CELLS) begin
        send_cell(($urandom_range(0, 4) == 0) ? 8'h00 : COLOR_W'($urandom_range(0, 255)),
                  pick_color(last_fg, cur_dfg), pick_color(last_bg, cur_dbg));
        burst--;
      end
    end

    settle();
    repeat (40) @(posedge clk);
    $display("%0d cells under %0d register settings, %0d bytes checked, %0d frames closed",
             cells_sent, settings_used, bytes_checked, frames_closed);
    if (mismatches == 0 && bytes_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/acte_pkg.sv
hw/rtl/acte_ifs.sv
hw/rtl/acte_sequencer.sv
hw/rtl/acte_datapath.sv
hw/rtl/ansi_cell_to_escape_encoder.sv
sim/acte_byte_stream_checker.sv
sim/ansi_cell_to_escape_encoder_tb.sv
